/* rtl/core/bilinear_rgba_downscaler_macros.svh */
// Assertion macros for the bilinear RGBA downscaler.
// Depends on nothing; included by the top level only.
`ifndef BILINEAR_RGBA_DOWNSCALER_MACROS_SVH
`define BILINEAR_RGBA_DOWNSCALER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BIRD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bird_pkg.sv */
// Shared types and constants of the bilinear RGBA downscaler.
// Depends on nothing; used by every module of the block.
package bird_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int SIZE_W    = 9;
   localparam int COORD_W   = 8;
   localparam int WORD_W    = 32;
   localparam int CH_W      = 8;
   localparam int FRAC_W    = 16;
   localparam int DIV_W     = 34;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 48;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [WORD_W-1:0]   word;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] src_w;
      logic [SIZE_W-1:0] src_h;
      logic [SIZE_W-1:0] dst_w;
      logic [SIZE_W-1:0] dst_h;
   } size_cfg_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_stat_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_stat_type;

endpackage

/* rtl/core/bilinear_rgba_downscaler.sv */
// Top level of the bilinear RGBA downscaler: configuration registers,
// front end, item queue and back end. Depends on bird_pkg and the macro header.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata col,row,rgba_word; tuser opcode
//   rsp      out        rsp_tvalid/rsp_tready  tdata red,green,blue,alpha,out_col,out_row
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A store is written to the image memory in the same cycle as it leaves the
// queue. A compute holds the back end: taken from the queue, index clamped,
// bit-serial position dividers (a set-up step, then one quotient bit a cycle
// for a 34-bit quotient, both axes side by side), neighbours fixed, per
// neighbour a read on the single memory read port, then multiply-accumulate,
// then the result register loads, waiting while an earlier result is held.
// Reset is synchronous and clears control state and the size registers to 1;
// the image memory is not cleared. A stalled result holds in the output
// register while the queue keeps taking items until it is full.
`include "bilinear_rgba_downscaler_macros.svh"

module bilinear_rgba_downscaler #(
   parameter int MAX_WIDTH  = bird_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bird_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bird_pkg::REQ_W-1:0]    req_tdata,  // col[7:0], row[15:8], rgba_word[47:16]
   input  logic                          req_tuser,  // opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bird_pkg::RSP_W-1:0]    rsp_tdata,  // red, green, blue, alpha, out_col, out_row
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bird_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bird_pkg::SIZE_W-1:0]   csr_data
);
   import bird_pkg::*;

   size_cfg_type   cfg_ff, cfg_in;
   queue_stat_type q_stat;
   back_stat_type  back_stat;
   item_type       push_item, q_item;
   logic           push;

   // size registers: always ready, unknown index ignored
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SOURCE_WIDTH:  cfg_in.src_w = csr_data;
            REG_SOURCE_HEIGHT: cfg_in.src_h = csr_data;
            REG_TARGET_WIDTH:  cfg_in.dst_w = csr_data;
            REG_TARGET_HEIGHT: cfg_in.dst_h = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{src_w: 9'd1, src_h: 9'd1, dst_w: 9'd1, dst_h: 9'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bird_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   bird_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .item_in (push_item),
      .pop     (back_stat.pop),
      .item_out(q_item),
      .stat    (q_stat)
   );

   bird_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .q_item    (q_item),
      .stat      (back_stat),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // back-pressure on the request side only comes from a full queue
   `BIRD_ASSERT_IMP(a_ready_full, clock, reset, !req_tready, q_stat.full, "ready low without full queue")
   // never take an item while a compute is in flight
   `BIRD_ASSERT_IMP(a_pop_idle, clock, reset, back_stat.busy, !back_stat.pop, "pop while busy")
   // a store never raises a result
   `BIRD_ASSERT_NEXT(a_store_silent, clock, reset, back_stat.pop && (q_item.kind == KIND_STORE) && !rsp_tvalid, !rsp_tvalid, "store raised a result")

endmodule

/* rtl/core/bird_front.sv */
// Front end: accepts request items, classifies store or compute, drops
// stores outside the image memory. Depends on bird_pkg.
module bird_front #(
   parameter int MAX_WIDTH  = bird_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bird_pkg::DEF_MAX_HEIGHT
) (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [bird_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tuser,
   input  bird_pkg::queue_stat_type  q_stat,
   output logic                      push,
   output bird_pkg::item_type        push_item
);
   import bird_pkg::*;

   logic in_range;

   assign push_item.kind = req_tuser;
   assign push_item.col  = req_tdata[7:0];
   assign push_item.row  = req_tdata[15:8];
   assign push_item.word = req_tdata[47:16];

   assign in_range = (32'(push_item.col) < MAX_WIDTH) && (32'(push_item.row) < MAX_HEIGHT);

   assign req_tready = !q_stat.full;
   // drop stores that fall outside the memory
   assign push = req_tvalid && !q_stat.full && ((push_item.kind == KIND_COMPUTE) || in_range);

endmodule

/* rtl/core/bird_queue.sv */
// Two-entry item queue between front and back end.
// Depends on bird_pkg.
module bird_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bird_pkg::item_type       item_in,
   input  logic                     pop,
   output bird_pkg::item_type       item_out,
   output bird_pkg::queue_stat_type stat
);
   import bird_pkg::*;

   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign item_out   = entry_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != 2'd0);
   assign stat.full  = (count_ff == 2'(QUEUE_DEPTH));

endmodule

/* rtl/core/bird_back.sv */
// Back end: image memory, position dividers, weight and accumulate sequencer,
// result register. Depends on bird_pkg.
module bird_back #(
   parameter int MAX_WIDTH  = bird_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bird_pkg::DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bird_pkg::size_cfg_type     cfg,
   input  bird_pkg::queue_stat_type   q_stat,
   input  bird_pkg::item_type         q_item,
   output bird_pkg::back_stat_type    stat,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bird_pkg::RSP_W-1:0] rsp_tdata
);
   import bird_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_FIX   = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int top);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > top) begin
         r = SIZE_W'(top);
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;

   logic [COORD_W-1:0] col_ff, row_ff;
   logic [SIZE_W-1:0]  src_ff [2];
   logic [SIZE_W-1:0]  dst_ff [2];
   logic [SIZE_W-1:0]  idx_ff [2];
   logic               neg_ff [2];
   logic [DIV_W-1:0]   dvd_ff [2];
   logic [SIZE_W:0]    rem_ff [2];
   logic [SIZE_W-1:0]  first_ff [2];
   logic [SIZE_W-1:0]  second_ff [2];
   logic [FRAC_W-1:0]  frac_ff [2];
   logic [5:0]         cnt_ff;
   logic [1:0]         k_ff;
   logic [DIV_W-1:0]   w_ff;
   logic [40:0]        acc_ff [4];
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic             mem_we, do_load;
   logic [AW-1:0]    waddr, raddr;
   logic [SIZE_W-1:0] xsel, ysel;
   logic [FRAC_W:0]  fa, fb;
   logic [RSP_W-1:0] result;

   always_comb begin
      state_in = state_ff;
      mem_we   = 1'b0;
      do_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_stat.valid) begin
               if (q_item.kind == KIND_STORE) begin
                  mem_we = 1'b1;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 6'(DIV_W)) state_in = ST_FIX;
         ST_FIX:   state_in = ST_READ;
         ST_READ:  state_in = ST_ACC;
         ST_ACC:   state_in = (k_ff == 2'd3) ? ST_OUT : ST_READ;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               do_load  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.pop  = (state_ff == ST_IDLE) && q_stat.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memory: one write port for stores, one registered read port
   assign waddr = AW'(32'(q_item.row) * MAX_WIDTH + 32'(q_item.col));
   assign xsel  = k_ff[0] ? second_ff[0] : first_ff[0];
   assign ysel  = k_ff[1] ? second_ff[1] : first_ff[1];
   assign raddr = AW'(32'(ysel) * MAX_WIDTH + 32'(xsel));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= q_item.word;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_ff <= mem[raddr];
      end
   end

   // weight factors: complement or fraction per axis
   assign fa = k_ff[1] ? {1'b0, frac_ff[1]} : 17'h10000 - {1'b0, frac_ff[1]};
   assign fb = k_ff[0] ? {1'b0, frac_ff[0]} : 17'h10000 - {1'b0, frac_ff[0]};

   always_ff @(posedge clock) begin
      logic [2*SIZE_W:0]  num;
      logic [10:0]        trial;
      logic [17:0]        qhi;
      logic [SIZE_W-1:0]  fst;
      logic [COORD_W-1:0] ic;
      logic [41:0]        prod;
      case (state_ff)
         ST_IDLE: begin
            col_ff    <= q_item.col;
            row_ff    <= q_item.row;
            src_ff[0] <= clamp_size(cfg.src_w, MAX_WIDTH);
            src_ff[1] <= clamp_size(cfg.src_h, MAX_HEIGHT);
            dst_ff[0] <= clamp_size(cfg.dst_w, 511);
            dst_ff[1] <= clamp_size(cfg.dst_h, 511);
         end
         ST_SETUP: begin
            for (int a = 0; a < 2; a++) begin
               ic = (a == 0) ? col_ff : row_ff;
               // hold the index inside the target
               idx_ff[a] <= (SIZE_W'(ic) > dst_ff[a] - 1'b1) ? dst_ff[a] - 1'b1 : SIZE_W'(ic);
            end
            cnt_ff <= '0;
         end
         default: ;
      endcase
      if (state_ff == ST_FIX) begin
         for (int a = 0; a < 2; a++) begin
            qhi = dvd_ff[a][DIV_W-1:FRAC_W];
            fst = (qhi > 18'(src_ff[a] - 1'b1)) ? src_ff[a] - 1'b1 : SIZE_W'(qhi);
            if (neg_ff[a]) fst = '0;
            first_ff[a]  <= fst;
            second_ff[a] <= (fst + 1'b1 < src_ff[a]) ? fst + 1'b1 : src_ff[a] - 1'b1;
            frac_ff[a]   <= neg_ff[a] ? '0 : dvd_ff[a][FRAC_W-1:0];
            acc_ff[2*a]   <= '0;
            acc_ff[2*a+1] <= '0;
         end
         k_ff <= 2'd0;
      end
      if (state_ff == ST_DIV) begin
         for (int a = 0; a < 2; a++) begin
            if (cnt_ff == 6'd0) begin
               // first division cycle: build dividend from the clamped index
               num = 19'({idx_ff[a][COORD_W-1:0], 1'b1}) * 19'(src_ff[a]);
               neg_ff[a] <= (num < 19'(dst_ff[a]));
               dvd_ff[a] <= {18'(num - 19'(dst_ff[a])), 16'b0};
               rem_ff[a] <= '0;
            end else begin
               trial = {rem_ff[a], dvd_ff[a][DIV_W-1]};
               if (trial >= 11'({dst_ff[a], 1'b0})) begin
                  rem_ff[a]  <= 10'(trial - 11'({dst_ff[a], 1'b0}));
                  dvd_ff[a]  <= {dvd_ff[a][DIV_W-2:0], 1'b1};
               end else begin
                  rem_ff[a]  <= trial[SIZE_W:0];
                  dvd_ff[a]  <= {dvd_ff[a][DIV_W-2:0], 1'b0};
               end
            end
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == ST_READ) begin
         w_ff <= {17'b0, fa} * {17'b0, fb};
      end
      if (state_ff == ST_ACC) begin
         for (int c = 0; c < 4; c++) begin
            prod = {8'b0, w_ff} * {34'b0, rd_ff[8*c +: 8]};
            acc_ff[c] <= acc_ff[c] + prod[40:0];
         end
         k_ff <= k_ff + 1'b1;
      end
      if (do_load) begin
         rsp_data_ff <= result;
      end
   end

   always_comb begin
      logic [40:0] rnd;
      for (int c = 0; c < 4; c++) begin
         rnd = acc_ff[c] + 41'h0_8000_0000;
         result[8*c +: 8] = (rnd[40:32] > 9'd255) ? 8'hFF : rnd[39:32];
      end
      result[39:32] = col_ff;
      result[47:40] = row_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/tb_bilinear_rgba_downscaler.sv */
// Self-checking testbench of the bilinear RGBA downscaler: drives stores and computes,
// predicts every interpolated pixel and compares it field by field. Depends on bird_pkg.
`timescale 1ns / 1ps

module tb_bilinear_rgba_downscaler;
   import bird_pkg::*;

   typedef struct packed {
      logic [7:0] out_row;
      logic [7:0] out_col;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;  // col, row, rgba_word
   logic                 req_tuser = 1'b0;  // opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;  // red, green, blue, alpha, out_col, out_row
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_data = '0;

   // Shadow copy of the source memory and the size registers.
   logic [31:0] image_mem [0:65535];
   bit          written [0:65535];
   logic [8:0]  src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;

   pixel_type   pending_pixels[$];
   int          fail_count = 0;
   bit          sink_idle = 1'b1;   // stall bursts on the result side enabled
   bit          source_idle = 1'b1; // gap bursts on the request side enabled
   int          hold_off = 0;       // long receiver stall, in cycles

   bilinear_rgba_downscaler u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100ms;
      $display("tb_bilinear_rgba_downscaler failed");
      $finish;
   end

   // Position along one axis: first neighbour, second neighbour, 16-bit fraction.
   function automatic void axis_locate(input int unsigned i, input int unsigned src,
                                       input int unsigned dst, output int unsigned first,
                                       output int unsigned second, output int unsigned frac);
      longint unsigned num, n, den;
      if (i > dst - 1) i = dst - 1;
      num = (2 * i + 1) * src;
      den = 2 * dst;
      if (num < dst) begin
         first = 0;
         frac = 0;
      end else begin
         n = num - dst;
         first = n / den;
         frac = (((n % den) << 16) / den) & 16'hFFFF;
      end
      if (first > src - 1) first = src - 1;
      second = (first + 1 < src) ? first + 1 : src - 1;
   endfunction

   function automatic int unsigned size_clamp(input int unsigned v, input int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic pixel_type interpolate(input logic [7:0] col, input logic [7:0] row);
      int unsigned x0, x1, fx, y0, y1, fy;
      longint unsigned w00, w01, w10, w11, acc, v;
      logic [31:0] p00, p01, p10, p11;
      logic [7:0]  chans [4];
      pixel_type   px;
      axis_locate(col, size_clamp(src_w_reg, 256), size_clamp(dst_w_reg, 511), x0, x1, fx);
      axis_locate(row, size_clamp(src_h_reg, 256), size_clamp(dst_h_reg, 511), y0, y1, fy);
      w00 = longint'(65536 - fy) * (65536 - fx);
      w01 = longint'(65536 - fy) * fx;
      w10 = longint'(fy) * (65536 - fx);
      w11 = longint'(fy) * fx;
      p00 = image_mem[y0 * 256 + x0];
      p01 = image_mem[y0 * 256 + x1];
      p10 = image_mem[y1 * 256 + x0];
      p11 = image_mem[y1 * 256 + x1];
      for (int c = 0; c < 4; c++) begin
         acc = w00 * p00[c*8 +: 8] + w01 * p01[c*8 +: 8]
             + w10 * p10[c*8 +: 8] + w11 * p11[c*8 +: 8];
         v = (acc + 64'h8000_0000) >> 32;
         chans[c] = (v > 255) ? 8'd255 : v[7:0];
      end
      px.red = chans[0];
      px.green = chans[1];
      px.blue = chans[2];
      px.alpha = chans[3];
      px.out_col = col;
      px.out_row = row;
      return px;
   endfunction

   // True when every neighbour a compute would read has been written.
   function automatic bit neighbours_written(input logic [7:0] col, input logic [7:0] row);
      int unsigned x0, x1, fx, y0, y1, fy;
      axis_locate(col, size_clamp(src_w_reg, 256), size_clamp(dst_w_reg, 511), x0, x1, fx);
      axis_locate(row, size_clamp(src_h_reg, 256), size_clamp(dst_h_reg, 511), y0, y1, fy);
      return written[y0*256+x0] && written[y0*256+x1] && written[y1*256+x0]
          && written[y1*256+x1];
   endfunction

   // Send one item; update the shadow memory or queue the expected pixel.
   // Valid stays high after the item is taken; drop it before a gap or in drain.
   task automatic send_item(input logic kind, input logic [7:0] col, input logic [7:0] row,
                            input logic [31:0] word);
      if (source_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {word, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_STORE) begin
         image_mem[row * 256 + col] = word;
         written[row * 256 + col] = 1'b1;
      end else
         pending_pixels.push_back(interpolate(col, row));
      @(negedge clock);
   endtask

   task automatic store_pixel(input int col, input int row, input logic [31:0] word);
      send_item(KIND_STORE, col[7:0], row[7:0], word);
   endtask

   task automatic compute_pixel(input int col, input int row);
      send_item(KIND_COMPUTE, col[7:0], row[7:0], 32'h0);
   endtask

   // Wait until every expected pixel has come, then for the compute latency.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // Valid stays high after the write; set_sizes drops it after the last one.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[8:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SOURCE_WIDTH:  src_w_reg = value[8:0];
         REG_SOURCE_HEIGHT: src_h_reg = value[8:0];
         REG_TARGET_WIDTH:  dst_w_reg = value[8:0];
         default:           dst_h_reg = value[8:0];
      endcase
      @(negedge clock);
   endtask

   task automatic set_sizes(input int sw, input int sh, input int tw, input int th);
      drain();
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      write_reg(REG_TARGET_WIDTH, tw);
      write_reg(REG_TARGET_HEIGHT, th);
      csr_valid <= 1'b0;
   endtask

   // Fill the source region so that no compute reads an unwritten entry.
   task automatic fill_source(input int sw, input int sh, input bit extremes);
      logic [31:0] w;
      for (int r = 0; r < sh; r++)
         for (int c = 0; c < sw; c++) begin
            w = extremes ? (((r + c) & 1) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
            store_pixel(c, r, w);
         end
   endtask

   // Directed: corners, saturating channels, beyond-target and out-of-range sizes.
   task automatic test_directed;
      set_sizes(4, 4, 2, 2);
      fill_source(4, 4, 1'b1);
      compute_pixel(0, 0);
      compute_pixel(1, 1);
      compute_pixel(255, 255); // outside the target: clamps, echoes the request
      set_sizes(3, 3, 3, 3);   // equal sizes: no interpolation
      store_pixel(1, 1, 32'hFFFF_FFFF);
      compute_pixel(1, 1);
      compute_pixel(2, 0);
      set_sizes(0, 0, 0, 0);   // zero size acts as one
      store_pixel(0, 0, 32'h8040_20FF);
      compute_pixel(0, 0);
      set_sizes(3, 2, 5, 4);   // target above source: upsamples
      compute_pixel(0, 0);
      compute_pixel(4, 3);
      compute_pixel(2, 1);
   endtask

   // Random images and sizes, with computes inside and beyond the target.
   task automatic test_random(input int items);
      int sw, sh, tw, th, sent, c, r;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 15) == 0) begin
            sw = $urandom_range(200, 256);
            sh = $urandom_range(1, 3);
         end else begin
            sw = $urandom_range(1, 8);
            sh = $urandom_range(1, 8);
         end
         tw = $urandom_range(1, sw);
         th = $urandom_range(1, sh);
         if ($urandom_range(0, 9) == 0) tw = $urandom_range(0, 511);
         if ($urandom_range(0, 9) == 0) th = $urandom_range(0, 511);
         if ($urandom_range(0, 19) == 0) sw = $urandom_range(257, 511);
         set_sizes(sw, sh, tw, th);
         if (sw > 256) begin
            fill_source(256, sh, 1'b0);
            sent += 256 * sh;
         end else begin
            fill_source(sw, sh, 1'b0);
            sent += sw * sh;
         end
         repeat ($urandom_range(10, 40)) begin
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, size_clamp(tw, 511) - 1);
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, size_clamp(th, 511) - 1);
            if ($urandom_range(0, 5) == 0) begin
               // stray store anywhere in the memory, random content
               store_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
            end
            if (neighbours_written(c[7:0], r[7:0])) begin
               compute_pixel(c, r);
               sent++;
            end
         end
      end
   endtask

   // Long receiver stall while computes keep coming, then a full pause and more computes.
   task automatic test_backpressure;
      set_sizes(4, 4, 3, 3);
      fill_source(4, 4, 1'b0);
      drain();
      hold_off = 600;
      for (int k = 0; k < 12; k++) compute_pixel(k % 3, k / 4);
      drain();
      for (int k = 0; k < 6; k++) compute_pixel(2, k % 3);
   endtask

   initial begin
      for (int i = 0; i < 65536; i++) begin
         image_mem[i] = 32'h0;
         written[i] = 1'b0;
      end
      src_w_reg = 9'd1;
      src_h_reg = 9'd1;
      dst_w_reg = 9'd1;
      dst_h_reg = 9'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(1700);
      // last stretch: no idling on either side
      sink_idle = 1'b0;
      source_idle = 1'b0;
      test_random(150);
      drain();
      if (fail_count == 0)
         $display("tb_bilinear_rgba_downscaler passed");
      else
         $display("tb_bilinear_rgba_downscaler failed");
      $finish;
   end

   // Result side readiness: random stall bursts plus the long hold-off.
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end else if (sink_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Compare each accepted pixel with the oldest expectation.
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red) begin
               $error("red expected %0d actual %0d", want.red, got.red);
               fail_count++;
            end
            if (got.green !== want.green) begin
               $error("green expected %0d actual %0d", want.green, got.green);
               fail_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue expected %0d actual %0d", want.blue, got.blue);
               fail_count++;
            end
            if (got.alpha !== want.alpha) begin
               $error("alpha expected %0d actual %0d", want.alpha, got.alpha);
               fail_count++;
            end
            if (got.out_col !== want.out_col) begin
               $error("out_col expected %0d actual %0d", want.out_col, got.out_col);
               fail_count++;
            end
            if (got.out_row !== want.out_row) begin
               $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
               fail_count++;
            end
         end
      end
   end

endmodule
